// ===== rtl/hall_sensor_position_speed_decoder_assert.svh =====
// Assertion macros shared by the Hall decoder RTL.
`ifndef HALL_SENSOR_POSITION_SPEED_DECODER_ASSERT_SVH
`define HALL_SENSOR_POSITION_SPEED_DECODER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HSD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/hsd_pkg.sv =====
// Types, constants and helper functions of the Hall sensor decoder.
package hsd_pkg;

  localparam int unsigned TimerModulus = 65535;
  localparam logic [16:0] TimerTicks   = 17'(TimerModulus + 1);

  localparam logic [2:0] SectorUndef = 3'd7;
  localparam logic [2:0] SectorCount = 3'd6;

  typedef enum logic [1:0] {
    RegInvertDirection = 2'd0,
    RegOverflowLimit   = 2'd1,
    RegMaxSpeedDelta   = 2'd2
  } hsd_reg_e;

  typedef struct packed {
    logic        invert_direction;
    logic [15:0] overflow_limit;
    logic [15:0] max_speed_delta;
  } hsd_cfg_t;

  typedef struct packed {
    logic        has_overflow;
    logic        has_capture;
    logic [2:0]  hall_bits;
    logic [15:0] capture_value;
    logic [15:0] timer_now;
    logic        rotation_cw;
  } hsd_item_t;

  typedef struct packed {
    logic [2:0]  sector;
    logic [31:0] position_count;
    logic [31:0] pulse_length;
    logic        pulse_valid;
    logic [31:0] undefined_errors;
    logic [31:0] big_step_errors;
    logic [31:0] no_change_errors;
    logic [31:0] speed_delta;
    logic        speed_valid;
  } hsd_result_t;

  // Hall pattern to commutation sector; 000 and 111 are invalid.
  localparam logic [2:0] SectorMap [8] = '{
    3'd7, 3'd5, 3'd3, 3'd4, 3'd1, 3'd0, 3'd2, 3'd7
  };

  // Signed sector step from prev to cur, folded into -2..3.
  function automatic logic signed [3:0] hsd_step(logic [2:0] prev, logic [2:0] cur);
    logic signed [3:0] diff;
    diff = signed'({1'b0, cur}) - signed'({1'b0, prev});
    if (diff > 4'sd3) begin
      diff = diff - signed'({1'b0, SectorCount});
    end else if (diff < -4'sd2) begin
      diff = diff + signed'({1'b0, SectorCount});
    end
    return diff;
  endfunction

endpackage

// ===== rtl/hsd_if.sv =====
// Valid/ready channel interfaces for Hall decoder items and results.
interface hsd_in_if;
  logic        valid;
  logic        ready;
  logic        has_overflow;
  logic        has_capture;
  logic [2:0]  hall_bits;
  logic [15:0] capture_value;
  logic [15:0] timer_now;
  logic        rotation_cw;

  modport source (
    output valid, has_overflow, has_capture, hall_bits, capture_value, timer_now,
           rotation_cw,
    input  ready
  );
  modport sink (
    input  valid, has_overflow, has_capture, hall_bits, capture_value, timer_now,
           rotation_cw,
    output ready
  );
endinterface

interface hsd_out_if;
  logic               valid;
  logic               ready;
  logic        [2:0]  sector;
  logic signed [31:0] position_count;
  logic        [31:0] pulse_length;
  logic               pulse_valid;
  logic        [31:0] undefined_errors;
  logic        [31:0] big_step_errors;
  logic        [31:0] no_change_errors;
  logic signed [31:0] speed_delta;
  logic               speed_valid;

  modport source (
    output valid, sector, position_count, pulse_length, pulse_valid, undefined_errors,
           big_step_errors, no_change_errors, speed_delta, speed_valid,
    input  ready
  );
  modport sink (
    input  valid, sector, position_count, pulse_length, pulse_valid, undefined_errors,
           big_step_errors, no_change_errors, speed_delta, speed_valid,
    output ready
  );
endinterface

// ===== rtl/hsd_cfg.sv =====
// APB register file holding the decoder configuration.
module hsd_cfg import hsd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output hsd_cfg_t    cfg_o
);

  hsd_cfg_t cfg_q;
  hsd_reg_e reg_sel;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_sel = hsd_reg_e'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite && pready;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.invert_direction <= 1'b0;
      cfg_q.overflow_limit   <= 16'd100;
      cfg_q.max_speed_delta  <= 16'd1000;
    end else if (wr_en) begin
      unique case (reg_sel)
        RegInvertDirection: cfg_q.invert_direction <= pwdata[0];
        RegOverflowLimit:   cfg_q.overflow_limit   <= pwdata[15:0];
        RegMaxSpeedDelta:   cfg_q.max_speed_delta  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      RegInvertDirection: prdata = {31'd0, cfg_q.invert_direction};
      RegOverflowLimit:   prdata = {16'd0, cfg_q.overflow_limit};
      RegMaxSpeedDelta:   prdata = {16'd0, cfg_q.max_speed_delta};
      default:            prdata = 32'd0;
    endcase
  end

endmodule

// ===== rtl/hall_sensor_position_speed_decoder.sv =====
// Top level of the Hall sensor position and speed decoder.
//
//   channel  | direction | handshake     | payload
//   ---------+-----------+---------------+-------------------------------------------
//   in_i     | input     | valid/ready   | overflow and capture flags, Hall bits, times
//   out_o    | output    | valid/ready   | sector, position, period, errors, speed
//   APB      | input     | psel/penable  | three configuration registers
//
// Each item passes two registers from input transfer to result: an input register,
// then one pass of decode, counter and speed logic into the result register.
// One item is accepted every cycle while results are taken; the state update in the second stage sets this.
// Reset is asynchronous and active low and clears the valid flags, decoder state and counters.
// When the result is not taken, the input register still fills, then ready drops.
`include "hall_sensor_position_speed_decoder_assert.svh"

module hall_sensor_position_speed_decoder import hsd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  hsd_in_if.sink      in_i,
  hsd_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  hsd_cfg_t cfg;

  hsd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Pipeline registers.
  logic        s1_valid_q;
  hsd_item_t   s1_q;
  logic        out_valid_q;
  hsd_result_t out_q, out_d;
  logic        s1_move;
  logic        in_xfer;

  // Decoder state.
  logic [15:0] ovc_q, ovc_d;
  logic [2:0]  prev_sector_q, prev_sector_d;
  logic [15:0] prev_cap_q, prev_cap_d;
  logic [31:0] step_cnt_q, step_cnt_d;
  logic [31:0] calo_q, calo_d;
  logic [31:0] period_q, period_d;
  logic [31:0] undef_cnt_q, undef_cnt_d;
  logic [31:0] big_cnt_q, big_cnt_d;
  logic [31:0] nochg_cnt_q, nochg_cnt_d;
  logic [31:0] speed_q, speed_d;

  assign s1_move    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_move;
  assign in_xfer    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (s1_move) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_q.has_overflow  <= in_i.has_overflow;
      s1_q.has_capture   <= in_i.has_capture;
      s1_q.hall_bits     <= in_i.hall_bits;
      s1_q.capture_value <= in_i.capture_value;
      s1_q.timer_now     <= in_i.timer_now;
      s1_q.rotation_cw   <= in_i.rotation_cw;
    end
    if (s1_move) begin
      out_q <= out_d;
    end
  end

  // Working values of the single pass.
  logic [16:0]        lim_p1;
  logic [15:0]        ovc_cap;
  logic [15:0]        ovc_inc;
  logic [15:0]        ovc_edge;
  logic [2:0]         cur_sector;
  logic signed [3:0]  step;
  logic signed [3:0]  step_eff;
  logic [32:0]        ovf_ticks;
  logic [31:0]        diff;
  logic [31:0]        mag;

  always_comb begin
    ovc_d         = ovc_q;
    prev_sector_d = prev_sector_q;
    prev_cap_d    = prev_cap_q;
    step_cnt_d    = step_cnt_q;
    calo_d        = calo_q;
    period_d      = period_q;
    undef_cnt_d   = undef_cnt_q;
    big_cnt_d     = big_cnt_q;
    nochg_cnt_d   = nochg_cnt_q;
    speed_d       = speed_q;
    out_d         = '0;
    out_d.sector  = prev_sector_q;

    // Overflow count saturates at limit plus one, and never past the counter range.
    lim_p1  = {1'b0, cfg.overflow_limit} + 17'd1;
    ovc_cap = lim_p1[16] ? 16'hFFFF : lim_p1[15:0];
    ovc_inc = (s1_q.has_overflow && (ovc_q < ovc_cap)) ? ovc_q + 16'd1 : ovc_q;
    ovc_d   = ovc_inc;

    // An overflow that came after the edge does not count toward this period.
    ovc_edge = (s1_q.has_overflow && (s1_q.timer_now < s1_q.capture_value) &&
                (ovc_inc != 16'd0)) ? ovc_inc - 16'd1 : ovc_inc;

    cur_sector = SectorMap[s1_q.hall_bits];
    step       = hsd_step(prev_sector_q, cur_sector);
    step_eff   = cfg.invert_direction ? -step : step;
    ovf_ticks  = ovc_edge * TimerTicks;

    if (s1_q.has_capture) begin
      out_d.sector = cur_sector;
      if (cur_sector == SectorUndef) begin
        undef_cnt_d = undef_cnt_q + 32'd1;
      end else begin
        if (prev_sector_q < SectorCount) begin
          if ((step > 4'sd1) || (step < -4'sd1)) begin
            big_cnt_d = big_cnt_q + 32'd1;
          end else if (step == 4'sd0) begin
            nochg_cnt_d = nochg_cnt_q + 32'd1;
          end
          step_cnt_d = step_cnt_q + 32'(step_eff);
          period_d   = {16'd0, s1_q.capture_value} + ovf_ticks[31:0] - {16'd0, prev_cap_q};
          out_d.pulse_valid = 1'b1;
        end
        prev_sector_d = cur_sector;
      end
      prev_cap_d = s1_q.capture_value;
      ovc_d      = 16'd0;
    end

    diff = calo_q - step_cnt_d;
    mag  = diff[31] ? (32'd0 - diff) : diff;
    if (s1_q.has_overflow) begin
      calo_d = step_cnt_d;
      if (mag <= {16'd0, cfg.max_speed_delta}) begin
        speed_d = (cfg.invert_direction != s1_q.rotation_cw) ? (32'd0 - diff) : diff;
        out_d.speed_valid = 1'b1;
      end
    end

    out_d.position_count   = step_cnt_d;
    out_d.pulse_length     = period_d;
    out_d.undefined_errors = undef_cnt_d;
    out_d.big_step_errors  = big_cnt_d;
    out_d.no_change_errors = nochg_cnt_d;
    out_d.speed_delta      = speed_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovc_q         <= 16'd0;
      prev_sector_q <= SectorUndef;
      prev_cap_q    <= 16'd0;
      step_cnt_q    <= 32'd0;
      calo_q        <= 32'd0;
      period_q      <= 32'd0;
      undef_cnt_q   <= 32'd0;
      big_cnt_q     <= 32'd0;
      nochg_cnt_q   <= 32'd0;
      speed_q       <= 32'd0;
    end else if (s1_move) begin
      ovc_q         <= ovc_d;
      prev_sector_q <= prev_sector_d;
      prev_cap_q    <= prev_cap_d;
      step_cnt_q    <= step_cnt_d;
      calo_q        <= calo_d;
      period_q      <= period_d;
      undef_cnt_q   <= undef_cnt_d;
      big_cnt_q     <= big_cnt_d;
      nochg_cnt_q   <= nochg_cnt_d;
      speed_q       <= speed_d;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.sector           = out_q.sector;
  assign out_o.position_count   = signed'(out_q.position_count);
  assign out_o.pulse_length     = out_q.pulse_length;
  assign out_o.pulse_valid      = out_q.pulse_valid;
  assign out_o.undefined_errors = out_q.undefined_errors;
  assign out_o.big_step_errors  = out_q.big_step_errors;
  assign out_o.no_change_errors = out_q.no_change_errors;
  assign out_o.speed_delta      = signed'(out_q.speed_delta);
  assign out_o.speed_valid      = out_q.speed_valid;

  `HSD_ASSERT_NOW(a_pulse_needs_sector, clk_i, rst_ni, out_valid_q && out_q.pulse_valid, out_q.sector != SectorUndef, "pulse reported with undefined sector")
  `HSD_ASSERT_NEXT(a_capture_clears_ovc, clk_i, rst_ni, s1_move && s1_q.has_capture, ovc_q == 16'd0, "overflow count not cleared by capture")
  `HSD_ASSERT_NOW(a_prev_sector_legal, clk_i, rst_ni, 1'b1, prev_sector_q != SectorCount, "previous sector holds an impossible code")
  `HSD_ASSERT_NOW(a_stall_only_when_full, clk_i, rst_ni, !in_i.ready, s1_valid_q && out_valid_q, "input stalled with room in the pipeline")

endmodule

// ===== tb/tb_hall_sensor_position_speed_decoder.sv =====
// Testbench for the Hall sensor decoder: drives random items, predicts and checks results.
`timescale 1ns / 100ps

module tb_hall_sensor_position_speed_decoder;
  import hsd_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam logic [2:0] HallOfSector [6] = '{
    3'b101, 3'b100, 3'b110, 3'b010, 3'b011, 3'b001
  };

  // Tracks the decoder state and holds the results that accepted items must produce.
  class hall_result_scoreboard;
    hsd_cfg_t    cfg;
    logic [15:0] ovf_count;
    logic [2:0]  last_sector;
    logic [15:0] last_capture;
    logic [31:0] position;
    logic [31:0] position_at_ovf;
    logic [31:0] period;
    logic [31:0] undef_errs;
    logic [31:0] big_step_errs;
    logic [31:0] no_change_errs;
    logic [31:0] speed;
    hsd_result_t pending_results[$];
    int unsigned failures;

    function new();
      cfg = '{invert_direction: 1'b0, overflow_limit: 16'd100, max_speed_delta: 16'd1000};
      ovf_count       = '0;
      last_sector     = SectorUndef;
      last_capture    = '0;
      position        = '0;
      position_at_ovf = '0;
      period          = '0;
      undef_errs      = '0;
      big_step_errs   = '0;
      no_change_errs  = '0;
      speed           = '0;
      failures        = 0;
    endfunction

    function void set_reg(hsd_reg_e idx, logic [31:0] value);
      case (idx)
        RegInvertDirection: cfg.invert_direction = value[0];
        RegOverflowLimit:   cfg.overflow_limit   = value[15:0];
        RegMaxSpeedDelta:   cfg.max_speed_delta  = value[15:0];
        default: ;
      endcase
    endfunction

    function logic [2:0] sector_of(logic [2:0] hall);
      case (hall)
        3'b101:  return 3'd0;
        3'b100:  return 3'd1;
        3'b110:  return 3'd2;
        3'b010:  return 3'd3;
        3'b011:  return 3'd4;
        3'b001:  return 3'd5;
        default: return SectorUndef;
      endcase
    endfunction

    function void note_item(hsd_item_t it);
      hsd_result_t res;
      logic [16:0] sat;
      logic [2:0]  sec;
      logic [31:0] diff;
      logic [31:0] mag;
      int          step;
      res = '0;
      res.sector = last_sector;
      if (it.has_overflow) begin
        sat = {1'b0, cfg.overflow_limit} + 17'd1;
        if (sat > 17'hFFFF) sat = 17'hFFFF;
        if ({1'b0, ovf_count} < sat) ovf_count++;
      end
      if (it.has_capture) begin
        // An overflow flagged with a capture that the timer has not reached yet
        // happened after the edge and must not count toward this period.
        if (it.has_overflow && it.timer_now < it.capture_value && ovf_count != 0) ovf_count--;
        sec = sector_of(it.hall_bits);
        res.sector = sec;
        if (sec == SectorUndef) begin
          undef_errs++;
        end else begin
          if (last_sector < SectorCount) begin
            step = (int'(sec) + 6 - int'(last_sector)) % 6;
            if (step > 3) step -= 6;
            if (step > 1 || step < -1) big_step_errs++;
            else if (step == 0) no_change_errs++;
            if (cfg.invert_direction) step = -step;
            position += step;
            period = 32'(it.capture_value) + 32'(ovf_count) * 32'd65536
                     - 32'(last_capture);
            res.pulse_valid = 1'b1;
          end
          last_sector = sec;
        end
        last_capture = it.capture_value;
        ovf_count    = '0;
      end
      if (it.has_overflow) begin
        diff = position_at_ovf - position;
        mag  = diff[31] ? -diff : diff;
        position_at_ovf = position;
        if (mag <= {16'b0, cfg.max_speed_delta}) begin
          if (cfg.invert_direction != it.rotation_cw) diff = -diff;
          speed = diff;
          res.speed_valid = 1'b1;
        end
      end
      res.position_count   = position;
      res.pulse_length     = period;
      res.undefined_errors = undef_errs;
      res.big_step_errors  = big_step_errs;
      res.no_change_errors = no_change_errs;
      res.speed_delta      = speed;
      pending_results.push_back(res);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
        failures++;
      end
    endfunction

    function void check_result(hsd_result_t got);
      hsd_result_t want;
      if (pending_results.size() == 0) begin
        $error("result transfer with no item outstanding (sector %0d)", got.sector);
        failures++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("sector", 32'(want.sector), 32'(got.sector));
      compare_field("position_count", want.position_count, got.position_count);
      compare_field("pulse_length", want.pulse_length, got.pulse_length);
      compare_field("pulse_valid", 32'(want.pulse_valid), 32'(got.pulse_valid));
      compare_field("undefined_errors", want.undefined_errors, got.undefined_errors);
      compare_field("big_step_errors", want.big_step_errors, got.big_step_errors);
      compare_field("no_change_errors", want.no_change_errors, got.no_change_errors);
      compare_field("speed_delta", want.speed_delta, got.speed_delta);
      compare_field("speed_valid", 32'(want.speed_valid), 32'(got.speed_valid));
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  hsd_in_if  in_if ();
  hsd_out_if out_if ();

  hall_result_scoreboard hall_sb;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_off_req;
  int unsigned hold_left;
  int unsigned cycle_count;

  // Stimulus state for well-formed rotation.
  int unsigned hall_idx;
  bit          spin_fwd;
  logic [15:0] timer_base;

  hall_sensor_position_speed_decoder dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb_hall_sensor_position_speed_decoder: FAIL");
    $finish;
  end

  // Result side: checks every transfer and paces ready.
  initial begin
    hsd_result_t got;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) begin
        got.sector           = out_if.sector;
        got.position_count   = out_if.position_count;
        got.pulse_length     = out_if.pulse_length;
        got.pulse_valid      = out_if.pulse_valid;
        got.undefined_errors = out_if.undefined_errors;
        got.big_step_errors  = out_if.big_step_errors;
        got.no_change_errors = out_if.no_change_errors;
        got.speed_delta      = out_if.speed_delta;
        got.speed_valid      = out_if.speed_valid;
        hall_sb.check_result(got);
      end
      if (hold_off_req != 0) begin
        hold_left    = hold_off_req;
        hold_off_req = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_item(hsd_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.has_overflow  <= it.has_overflow;
    in_if.has_capture   <= it.has_capture;
    in_if.hall_bits     <= it.hall_bits;
    in_if.capture_value <= it.capture_value;
    in_if.timer_now     <= it.timer_now;
    in_if.rotation_cw   <= it.rotation_cw;
    do @(posedge clk_i); while (!in_if.ready);
    hall_sb.note_item(it);
  endtask

  task automatic send_fields(bit ovf, bit cap, logic [2:0] hall, logic [15:0] cval,
                             logic [15:0] tnow, bit cw);
    hsd_item_t it;
    it = '{has_overflow: ovf, has_capture: cap, hall_bits: hall, capture_value: cval,
           timer_now: tnow, rotation_cw: cw};
    send_item(it);
  endtask

  task automatic send_random(int unsigned count);
    hsd_item_t it;
    repeat (count) begin
      it.has_overflow = ($urandom_range(99) < 30);
      it.has_capture  = ($urandom_range(99) < 60);
      it.rotation_cw  = 1'($urandom_range(1));
      it.timer_now    = 16'($urandom);
      if ($urandom_range(99) < 85) begin
        if ($urandom_range(99) < 6) spin_fwd = !spin_fwd;
        if (it.has_capture) begin
          if (spin_fwd) hall_idx = (hall_idx == 5) ? 0 : hall_idx + 1;
          else hall_idx = (hall_idx == 0) ? 5 : hall_idx - 1;
        end
        timer_base       = timer_base + 16'($urandom_range(4000, 1));
        it.hall_bits     = HallOfSector[hall_idx];
        it.capture_value = timer_base;
      end else begin
        it.hall_bits     = 3'($urandom_range(7));
        it.capture_value = 16'($urandom);
      end
      send_item(it);
    end
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (hall_sb.pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic apb_write(hsd_reg_e idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    hall_sb.set_reg(idx, value);
  endtask

  task automatic write_config(bit inv, logic [15:0] lim, logic [15:0] max_delta);
    apb_write(RegInvertDirection, {31'b0, inv});
    apb_write(RegOverflowLimit, {16'b0, lim});
    apb_write(RegMaxSpeedDelta, {16'b0, max_delta});
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic run_directed();
    send_fields(1'b0, 1'b0, 3'b000, 16'h0000, 16'h0000, 1'b0);  // nothing happens
    send_fields(1'b1, 1'b0, 3'b111, 16'hFFFF, 16'hFFFF, 1'b1);
    send_fields(1'b0, 1'b1, 3'b101, 16'h0010, 16'h0000, 1'b0);  // first edge, no period
    send_fields(1'b1, 1'b0, 3'b000, 16'h0000, 16'h0000, 1'b1);
    send_fields(1'b1, 1'b0, 3'b000, 16'h0000, 16'h0000, 1'b0);
    send_fields(1'b0, 1'b1, 3'b100, 16'hFFFF, 16'hFFFF, 1'b1);  // one step forward
    send_fields(1'b0, 1'b1, 3'b100, 16'h1234, 16'h4321, 1'b0);  // unchanged sector
    send_fields(1'b0, 1'b1, 3'b010, 16'h2000, 16'h0000, 1'b1);  // jump of two
    send_fields(1'b0, 1'b1, 3'b101, 16'h3000, 16'h0000, 1'b1);  // opposite sector
    send_fields(1'b0, 1'b1, 3'b011, 16'h4000, 16'h0000, 1'b0);  // jump of two backward
    send_fields(1'b0, 1'b1, 3'b010, 16'h5000, 16'h0000, 1'b0);  // one step backward
    send_fields(1'b0, 1'b1, 3'b000, 16'h6000, 16'h0000, 1'b0);
    send_fields(1'b0, 1'b1, 3'b111, 16'h7000, 16'h0000, 1'b1);
    send_fields(1'b0, 1'b1, 3'b110, 16'h7100, 16'h0000, 1'b1);
    send_fields(1'b1, 1'b0, 3'b000, 16'h0000, 16'h0000, 1'b0);
    send_fields(1'b1, 1'b1, 3'b010, 16'h8000, 16'h0100, 1'b1);  // overflow after the edge
    send_fields(1'b1, 1'b1, 3'b011, 16'h0100, 16'h8000, 1'b0);  // overflow before the edge
    send_fields(1'b0, 1'b1, 3'b001, 16'h0000, 16'h0000, 1'b1);
    send_fields(1'b1, 1'b1, 3'b000, 16'hF000, 16'h0001, 1'b1);  // overflow with bad pattern
    send_fields(1'b0, 1'b1, 3'b100, 16'hFFFF, 16'hFFFE, 1'b0);
    send_fields(1'b1, 1'b0, 3'b101, 16'hAAAA, 16'h5555, 1'b1);
  endtask

  initial begin
    hall_sb        = new();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_req   = 0;
    hold_left      = 0;
    hall_idx       = 0;
    spin_fwd       = 1'b1;
    timer_base     = '0;
    rst_ni              <= 1'b0;
    in_if.valid         <= 1'b0;
    in_if.has_overflow  <= 1'b0;
    in_if.has_capture   <= 1'b0;
    in_if.hall_bits     <= '0;
    in_if.capture_value <= '0;
    in_if.timer_now     <= '0;
    in_if.rotation_cw   <= 1'b0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    drain();

    // Tight limits: the overflow count saturates at two and only still periods pass.
    write_config(1'b1, 16'd1, 16'd0);
    repeat (3) send_fields(1'b1, 1'b0, 3'b000, 16'h0000, 16'h0000, 1'b1);
    send_fields(1'b0, 1'b1, 3'b101, 16'h0040, 16'h0000, 1'b0);
    send_random(130);
    drain();

    write_config(1'b0, 16'd65534, 16'd65535);
    send_idle_pct = 45;
    send_random(130);
    drain();

    write_config(1'b1, 16'd3, 16'd2);
    send_idle_pct  = 0;
    recv_stall_pct = 45;
    send_random(70);
    drain();
    send_random(70);
    drain();

    // Long receiver hold-off while the sender keeps offering items back to back.
    write_config(1'b0, 16'd100, 16'd5);
    recv_stall_pct = 13;
    hold_off_req   = 160;
    send_random(40);
    send_idle_pct = 13;
    send_random(100);
    drain();

    repeat (8) @(posedge clk_i);
    if (hall_sb.failures == 0 && hall_sb.pending_results.size() == 0) begin
      $display("tb_hall_sensor_position_speed_decoder: PASS");
    end else begin
      $display("tb_hall_sensor_position_speed_decoder: FAIL");
    end
    $finish;
  end

endmodule
